@@ rtl/utf8_decoder_cjk_classifier_core_defines.svh @@
// Assertion macros shared by the UTF-8 decoder RTL.
`ifndef UTF8_DECODER_CJK_CLASSIFIER_CORE_DEFINES_SVH
`define UTF8_DECODER_CJK_CLASSIFIER_CORE_DEFINES_SVH

`ifndef ASSERT_OFF

// Check that cons holds in the cycle where ante holds.
`define U8_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("u8cjk assertion failed");

// Check that cons holds in the cycle after ante holds.
`define U8_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("u8cjk assertion failed");

`else

`define U8_ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define U8_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

@@ rtl/u8cjk_pkg.sv @@
// Types and constants of the UTF-8 decoder with CJK classifier.
`timescale 1ns / 1ps

package u8cjk_pkg;

   localparam int unsigned ByteW = 8;
   localparam int unsigned CpW   = 21;
   localparam int unsigned LenW  = 3;
   localparam int unsigned RemW  = 2;

   localparam logic [LenW-1:0] LEN_NONE = 3'd0;
   localparam logic [LenW-1:0] LEN_ONE  = 3'd1;
   localparam logic [LenW-1:0] LEN_TWO  = 3'd2;
   localparam logic [LenW-1:0] LEN_THREE = 3'd3;
   localparam logic [LenW-1:0] LEN_FOUR = 3'd4;

   // CJK ranges: unified ideographs, extension A, compatibility ideographs
   localparam logic [CpW-1:0] CJK_MAIN_LO = 21'h004E00;
   localparam logic [CpW-1:0] CJK_MAIN_HI = 21'h009FFF;
   localparam logic [CpW-1:0] CJK_EXTA_LO = 21'h003400;
   localparam logic [CpW-1:0] CJK_EXTA_HI = 21'h004DBF;
   localparam logic [CpW-1:0] CJK_COMP_LO = 21'h00F900;
   localparam logic [CpW-1:0] CJK_COMP_HI = 21'h00FAFF;

   typedef struct packed {
      logic [ByteW-1:0] text_byte;
      logic             end_of_string;
   } req_item_type;

   typedef struct packed {
      logic             emit;
      logic [CpW-1:0]   code_point;
      logic [LenW-1:0]  byte_length;
      logic             is_cjk;
   } result_type;

   function automatic logic in_cjk(input logic [CpW-1:0] cp);
      in_cjk = ((cp >= CJK_MAIN_LO) && (cp <= CJK_MAIN_HI)) ||
               ((cp >= CJK_EXTA_LO) && (cp <= CJK_EXTA_HI)) ||
               ((cp >= CJK_COMP_LO) && (cp <= CJK_COMP_HI));
   endfunction

endpackage

@@ rtl/u8cjk_in_stage.sv @@
// Input register stage: holds one accepted request byte.
`timescale 1ns / 1ps

module u8cjk_in_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  u8cjk_pkg::req_item_type req_item,
   input  logic                  out_free,
   output logic                  item_valid,
   output u8cjk_pkg::req_item_type item
);

   logic                    valid_ff;
   logic                    valid_in;
   u8cjk_pkg::req_item_type item_ff;

   // Advance when empty or when the held byte moves on this cycle.
   assign req_tready = !valid_ff || out_free;
   assign valid_in   = req_tready ? req_tvalid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (req_tready && req_tvalid) begin
         item_ff <= req_item;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

@@ rtl/u8cjk_decode.sv @@
// Decoder state and per-byte decode and classify logic.
`timescale 1ns / 1ps
`include "utf8_decoder_cjk_classifier_core_defines.svh"

module u8cjk_decode (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_wr_en,
   input  logic                    csr_wr_data,
   input  logic                    item_valid,
   input  u8cjk_pkg::req_item_type item,
   input  logic                    out_free,
   output u8cjk_pkg::result_type   result
);

   logic [u8cjk_pkg::RemW-1:0] rem_ff, rem_in;
   logic [u8cjk_pkg::LenW-1:0] len_ff, len_in;
   logic [u8cjk_pkg::CpW-1:0]  pv_ff, pv_in;
   logic                       cjk_only_ff;

   logic [u8cjk_pkg::RemW-1:0] rem_dec;
   logic [u8cjk_pkg::CpW-1:0]  pv_shift;
   logic [u8cjk_pkg::ByteW-1:0] b;
   logic                        done;
   logic [u8cjk_pkg::CpW-1:0]  cp;
   logic [u8cjk_pkg::LenW-1:0] len;
   logic                        cjk;
   logic                        step;

   assign b        = item.text_byte;
   assign step     = item_valid && out_free;
   assign rem_dec  = rem_ff - u8cjk_pkg::RemW'(1);
   assign pv_shift = {pv_ff[u8cjk_pkg::CpW-7:0], b[5:0]};

   always_comb begin
      rem_in = '0;
      len_in = u8cjk_pkg::LEN_NONE;
      pv_in  = '0;
      done   = 1'b0;
      cp     = '0;
      len    = u8cjk_pkg::LEN_NONE;
      if ((rem_ff != '0) && (b[7:6] == 2'b10)) begin
         if (rem_dec == '0) begin
            done = 1'b1;
            cp   = pv_shift;
            len  = len_ff;
         end else begin
            rem_in = rem_dec;
            len_in = len_ff;
            pv_in  = pv_shift;
         end
      end else if (b[7] == 1'b0) begin
         done = 1'b1;
         cp   = u8cjk_pkg::CpW'(b);
         len  = u8cjk_pkg::LEN_ONE;
      end else if (b[7:5] == 3'b110) begin
         rem_in = 2'd1;
         len_in = u8cjk_pkg::LEN_TWO;
         pv_in  = u8cjk_pkg::CpW'(b[4:0]);
      end else if (b[7:4] == 4'b1110) begin
         rem_in = 2'd2;
         len_in = u8cjk_pkg::LEN_THREE;
         pv_in  = u8cjk_pkg::CpW'(b[3:0]);
      end else if (b[7:3] == 5'b11110) begin
         rem_in = 2'd3;
         len_in = u8cjk_pkg::LEN_FOUR;
         pv_in  = u8cjk_pkg::CpW'(b[2:0]);
      end
      // drop any open sequence at the end of the string
      if (item.end_of_string) begin
         rem_in = '0;
         len_in = u8cjk_pkg::LEN_NONE;
         pv_in  = '0;
      end
   end

   assign cjk = u8cjk_pkg::in_cjk(cp);

   always_comb begin
      result.emit        = item_valid && done && (!cjk_only_ff || cjk);
      result.code_point  = cp;
      result.byte_length = len;
      result.is_cjk      = cjk;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff      <= '0;
         len_ff      <= u8cjk_pkg::LEN_NONE;
         pv_ff       <= '0;
         cjk_only_ff <= 1'b1;
      end else begin
         if (step) begin
            rem_ff <= rem_in;
            len_ff <= len_in;
            pv_ff  <= pv_in;
         end
         if (csr_wr_en) begin
            cjk_only_ff <= csr_wr_data;
         end
      end
   end

   `U8_ASSERT_IMPLY(a_idle_clear, clock, reset, rem_ff == '0, (len_ff == u8cjk_pkg::LEN_NONE) && (pv_ff == '0))
   `U8_ASSERT_IMPLY(a_open_len, clock, reset, rem_ff != '0, (len_ff > 3'(rem_ff)) && (len_ff <= u8cjk_pkg::LEN_FOUR))
   `U8_ASSERT_NEXT(a_eos_close, clock, reset, step && item.end_of_string, rem_ff == '0)

endmodule

@@ rtl/u8cjk_out_stage.sv @@
// Result register stage: holds one decoded character until taken.
`timescale 1ns / 1ps

module u8cjk_out_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  item_valid,
   input  u8cjk_pkg::result_type result,
   output logic                  out_free,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output u8cjk_pkg::result_type rsp_item
);

   logic                  valid_ff;
   logic                  valid_in;
   u8cjk_pkg::result_type item_ff;

   // Free when empty or when the held result leaves this cycle.
   assign out_free = !valid_ff || rsp_ready;
   assign valid_in = out_free ? (item_valid && result.emit) : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (out_free) begin
         item_ff <= result;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_item  = item_ff;

endmodule

@@ rtl/utf8_decoder_cjk_classifier_core.sv @@
// Top level of the streaming UTF-8 decoder with CJK classifier.
//
//   Port group   Direction  Carries
//   req_*        in         one text byte per request, tlast marks end of string
//   rsp_*        out        at most one character per request: code point, length, CJK flag
//   csr_*        in         cjk_only register write (no read-back)
//
// An accepted byte passes through the input register, then decode logic into
// the result register. One byte is accepted every cycle unless the result stalls.
// Synchronous reset empties both registers, closes any open sequence and sets
// cjk_only. A stalled result holds its register; the input register keeps
// accepting as long as the result register can take what it holds.
`timescale 1ns / 1ps
`include "utf8_decoder_cjk_classifier_core_defines.svh"

module utf8_decoder_cjk_classifier_core (
   input  logic        clock,
   input  logic        reset,
   // tdata: text_byte [7:0]
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,
   input  logic        req_tlast,
   // tdata: code_point [20:0], byte_length [23:21]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,
   // tuser: is_cjk [0]
   output logic        rsp_tuser,
   input  logic        csr_wr_en,
   input  logic        csr_wr_data
);

   u8cjk_pkg::req_item_type req_item;
   u8cjk_pkg::req_item_type item;
   u8cjk_pkg::result_type   result;
   u8cjk_pkg::result_type   rsp_item;
   logic                    item_valid;
   logic                    out_free;

   assign req_item.text_byte     = req_tdata;
   assign req_item.end_of_string = req_tlast;

   // Hold the accepted request byte.
   u8cjk_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_item   (req_item),
      .out_free   (out_free),
      .item_valid (item_valid),
      .item       (item)
   );

   // Advance the sequence state and classify the finished character.
   u8cjk_decode u_dec (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .item_valid  (item_valid),
      .item        (item),
      .out_free    (out_free),
      .result      (result)
   );

   // Hold the result until the downstream side takes it.
   u8cjk_out_stage u_out (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .result     (result),
      .out_free   (out_free),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_item   (rsp_item)
   );

   assign rsp_tdata = {rsp_item.byte_length, rsp_item.code_point};
   assign rsp_tuser = rsp_item.is_cjk;

   `U8_ASSERT_IMPLY(a_rsp_len, clock, reset, rsp_tvalid, (rsp_tdata[23:21] != 3'd0) && (rsp_tdata[23:21] <= 3'd4))
   `U8_ASSERT_IMPLY(a_rsp_cjk, clock, reset, rsp_tvalid, rsp_tuser == u8cjk_pkg::in_cjk(rsp_tdata[20:0]))

endmodule

@@ tb/sv/tb_utf8_decoder_cjk_classifier_core.sv @@
// Testbench for the streaming UTF-8 decoder with CJK classifier.
`timescale 1ns / 1ps

module tb_utf8_decoder_cjk_classifier_core;

   // Cycle budget for the whole run; far above the slowest correct run.
   localparam int unsigned CYCLE_LIMIT = 300000;
   // Receiver hold-off that fills the block and stalls its input.
   localparam int unsigned LONG_HOLD   = 400;
   // Idle cycles before a register write; covers the two-stage pipe.
   localparam int unsigned DRAIN_PAUSE = 6;

   // One decoded character as it appears on the result channel.
   typedef struct packed {
      logic [u8cjk_pkg::CpW-1:0]  code_point;
      logic [u8cjk_pkg::LenW-1:0] byte_length;
      logic                       is_cjk;
   } decoded_char_type;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata   = 8'h00;
   logic        req_tlast   = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [23:0] rsp_tdata;
   logic        rsp_tuser;
   logic        csr_wr_en   = 1'b0;
   logic        csr_wr_data = 1'b0;

   // Bytes waiting to be offered, and the characters the decoder owes us.
   u8cjk_pkg::req_item_type text_bytes[$];
   decoded_char_type        owed_chars[$];

   // Decoder state mirrored on every accepted request.
   logic [u8cjk_pkg::RemW-1:0] seq_left;
   logic [u8cjk_pkg::LenW-1:0] seq_len;
   logic [u8cjk_pkg::CpW-1:0]  seq_val;
   logic                       cjk_only_mirror;

   int unsigned bytes_queued   = 0;
   int unsigned bytes_accepted = 0;
   int unsigned fail_cnt       = 0;
   int unsigned cycle_cnt      = 0;

   // Idling switches and the one-shot long hold-off, set from the stimulus.
   bit tx_idle_on    = 1'b0;
   bit rx_idle_on    = 1'b0;
   bit long_hold_arm = 1'b0;
   bit long_hold_done;

   int unsigned tx_gap;
   int unsigned rx_stall;
   int unsigned rx_hold;

   utf8_decoder_cjk_classifier_core u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #5 clock = ~clock;

   // ------------------------------------------------------------------
   // Decoder mirror
   // ------------------------------------------------------------------

   function automatic logic is_cjk_point(input logic [u8cjk_pkg::CpW-1:0] cp);
      return (cp >= u8cjk_pkg::CJK_MAIN_LO && cp <= u8cjk_pkg::CJK_MAIN_HI) ||
             (cp >= u8cjk_pkg::CJK_EXTA_LO && cp <= u8cjk_pkg::CJK_EXTA_HI) ||
             (cp >= u8cjk_pkg::CJK_COMP_LO && cp <= u8cjk_pkg::CJK_COMP_HI);
   endfunction

   function automatic void close_sequence();
      seq_left = '0;
      seq_len  = u8cjk_pkg::LEN_NONE;
      seq_val  = '0;
   endfunction

   // Advance the mirror by one accepted byte and queue the character it
   // finishes, unless the CJK filter drops it.
   function automatic void decode_byte(input logic [7:0] b, input logic eos);
      decoded_char_type ch;
      logic             done;
      done = 1'b0;
      ch   = '0;
      if (seq_left != '0 && b[7:6] == 2'b10) begin
         // Continuation: shift in six more bits.
         seq_val  = {seq_val[u8cjk_pkg::CpW-7:0], b[5:0]};
         seq_left = seq_left - 1'b1;
         if (seq_left == '0) begin
            done           = 1'b1;
            ch.code_point  = seq_val;
            ch.byte_length = seq_len;
            close_sequence();
         end
      end else begin
         // Any open sequence is broken here; decode this byte as a lead.
         close_sequence();
         if (b[7] == 1'b0) begin
            done           = 1'b1;
            ch.code_point  = {{(u8cjk_pkg::CpW-8){1'b0}}, b};
            ch.byte_length = u8cjk_pkg::LEN_ONE;
         end else if (b[7:5] == 3'b110) begin
            seq_val  = {{(u8cjk_pkg::CpW-5){1'b0}}, b[4:0]};
            seq_left = 2'd1;
            seq_len  = u8cjk_pkg::LEN_TWO;
         end else if (b[7:4] == 4'b1110) begin
            seq_val  = {{(u8cjk_pkg::CpW-4){1'b0}}, b[3:0]};
            seq_left = 2'd2;
            seq_len  = u8cjk_pkg::LEN_THREE;
         end else if (b[7:3] == 5'b11110) begin
            seq_val  = {{(u8cjk_pkg::CpW-3){1'b0}}, b[2:0]};
            seq_left = 2'd3;
            seq_len  = u8cjk_pkg::LEN_FOUR;
         end
         // stray continuation or 11111xxx lead: skip
      end
      if (eos)
         close_sequence();
      if (done) begin
         ch.is_cjk = is_cjk_point(ch.code_point);
         if (!(cjk_only_mirror && !ch.is_cjk))
            owed_chars = {owed_chars, ch};
      end
   endfunction

   // ------------------------------------------------------------------
   // Request driver: offer queued bytes, mirror every accepted one
   // ------------------------------------------------------------------

   always @(posedge clock) begin
      u8cjk_pkg::req_item_type item;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= 8'h00;
         req_tlast  <= 1'b0;
         tx_gap     <= 0;
      end else begin
         if (req_tvalid && req_tready) begin
            decode_byte(req_tdata, req_tlast);
            bytes_accepted++;
         end
         // Only touch the request once the current one is gone.
         if (!req_tvalid || req_tready) begin
            if (tx_gap != 0) begin
               tx_gap     <= tx_gap - 1;
               req_tvalid <= 1'b0;
            end else if (text_bytes.size() != 0) begin
               item = text_bytes.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= item.text_byte;
               req_tlast  <= item.end_of_string;
               // Gap ahead of the following request.
               tx_gap     <= tx_idle_on ? $urandom_range(0, 8) : 0;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Long receiver hold-off, counted on its own
   // ------------------------------------------------------------------

   always @(posedge clock) begin
      if (reset) begin
         rx_hold        <= 0;
         long_hold_done <= 1'b0;
      end else if (rx_hold != 0) begin
         rx_hold <= rx_hold - 1;
      end else if (long_hold_arm && !long_hold_done && rsp_tvalid) begin
         // One long hold-off, started while results are flowing.
         rx_hold        <= LONG_HOLD;
         long_hold_done <= 1'b1;
      end
   end

   // ------------------------------------------------------------------
   // Result monitor: random back-pressure and field checks
   // ------------------------------------------------------------------

   always @(posedge clock) begin
      decoded_char_type want;
      decoded_char_type got;
      int unsigned      stall_nxt;
      if (reset) begin
         rsp_tready <= 1'b0;
         rx_stall   <= 0;
      end else begin
         stall_nxt = rx_stall;
         if (rsp_tvalid && rsp_tready) begin
            got.code_point  = rsp_tdata[u8cjk_pkg::CpW-1:0];
            got.byte_length = rsp_tdata[u8cjk_pkg::CpW+u8cjk_pkg::LenW-1:u8cjk_pkg::CpW];
            got.is_cjk      = rsp_tuser;
            if (owed_chars.size() == 0) begin
               $display("%0t: unexpected character: expected none, actual cp=%06h",
                        $time, got.code_point);
               fail_cnt++;
            end else begin
               want = owed_chars.pop_front();
               if (got.code_point !== want.code_point) begin
                  $display("%0t: code_point mismatch: expected %06h, actual %06h",
                           $time, want.code_point, got.code_point);
                  fail_cnt++;
               end
               if (got.byte_length !== want.byte_length) begin
                  $display("%0t: byte_length mismatch: expected %0d, actual %0d",
                           $time, want.byte_length, got.byte_length);
                  fail_cnt++;
               end
               if (got.is_cjk !== want.is_cjk) begin
                  $display("%0t: is_cjk mismatch: expected %0b, actual %0b",
                           $time, want.is_cjk, got.is_cjk);
                  fail_cnt++;
               end
            end
            // Stall drawn for the next result.
            stall_nxt = rx_idle_on ? $urandom_range(0, 8) : 0;
         end else if (stall_nxt != 0) begin
            stall_nxt--;
         end
         rx_stall   <= stall_nxt;
         rsp_tready <= (stall_nxt == 0) && (rx_hold == 0);
      end
   end

   // ------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------

   task automatic queue_byte(input logic [7:0] b, input logic eos);
      u8cjk_pkg::req_item_type item;
      item.text_byte     = b;
      item.end_of_string = eos;
      text_bytes = {text_bytes, item};
      bytes_queued++;
   endtask

   // Encode cp in len bytes, leave off the last cut bytes, and put the
   // end-of-string flag on the last byte sent if eos is set.
   task automatic queue_char(input logic [u8cjk_pkg::CpW-1:0] cp, input int unsigned len,
                             input int unsigned cut, input logic eos);
      logic [7:0]  enc[4];
      int unsigned n;
      case (len)
         1: enc[0] = {1'b0, cp[6:0]};
         2: begin
            enc[0] = {3'b110, cp[10:6]};
            enc[1] = {2'b10, cp[5:0]};
         end
         3: begin
            enc[0] = {4'b1110, cp[15:12]};
            enc[1] = {2'b10, cp[11:6]};
            enc[2] = {2'b10, cp[5:0]};
         end
         default: begin
            enc[0] = {5'b11110, cp[20:18]};
            enc[1] = {2'b10, cp[17:12]};
            enc[2] = {2'b10, cp[11:6]};
            enc[3] = {2'b10, cp[5:0]};
         end
      endcase
      n = len - cut;
      for (int unsigned i = 0; i < n; i++)
         queue_byte(enc[i], eos && (i == n - 1));
   endtask

   // Mostly well-formed text with random content, code points clustered on
   // the CJK range edges, plus truncated characters, stray end-of-string
   // flags and raw noise bytes.
   task automatic queue_random_text(input int unsigned n_bytes, input bit cjk_heavy);
      logic [u8cjk_pkg::CpW-1:0] edges[6];
      logic [u8cjk_pkg::CpW-1:0] cp;
      int unsigned               start;
      int unsigned               len;
      int unsigned               cut;
      edges = '{u8cjk_pkg::CJK_MAIN_LO, u8cjk_pkg::CJK_MAIN_HI,
                u8cjk_pkg::CJK_EXTA_LO, u8cjk_pkg::CJK_EXTA_HI,
                u8cjk_pkg::CJK_COMP_LO, u8cjk_pkg::CJK_COMP_HI};
      start = bytes_queued;
      while (bytes_queued - start < n_bytes) begin
         if ($urandom_range(0, 99) < 6) begin
            queue_byte(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
         end else begin
            if ($urandom_range(0, 99) < (cjk_heavy ? 60 : 30)) begin
               cp  = u8cjk_pkg::CpW'(edges[$urandom_range(0, 5)] + $urandom_range(0, 4) - 2);
               len = ($urandom_range(0, 3) == 0) ? 4 : 3;
            end else begin
               len = $urandom_range(1, 4);
               cp  = u8cjk_pkg::CpW'($urandom);
               case (len)
                  1: cp = cp & 21'h00007F;
                  2: cp = cp & 21'h0007FF;
                  3: cp = cp & 21'h00FFFF;
                  default: ;
               endcase
            end
            cut = (len > 1 && $urandom_range(0, 9) == 0) ? $urandom_range(1, len - 1) : 0;
            queue_char(cp, len, cut, $urandom_range(0, 11) == 0);
         end
      end
   endtask

   // Hold the sender until every queued byte is in and every owed character
   // is out, then let the pipe settle.
   task automatic wait_drained();
      while (bytes_accepted != bytes_queued || owed_chars.size() != 0)
         @(posedge clock);
      repeat (DRAIN_PAUSE) @(posedge clock);
   endtask

   task automatic write_cjk_only(input logic value);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      cjk_only_mirror = value;
   endtask

   initial begin
      cjk_only_mirror = 1'b1;
      close_sequence();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed text under the reset filter: CJK edge code points pass,
      // plain ASCII is filtered, and the flagged final byte completes U+FAFF.
      queue_char(u8cjk_pkg::CJK_MAIN_LO, 3, 0, 1'b0);
      queue_byte(8'h41, 1'b0);
      queue_char(u8cjk_pkg::CJK_COMP_HI, 3, 0, 1'b1);
      wait_drained();

      write_cjk_only(1'b0);
      queue_byte(8'h00, 1'b0);
      queue_byte(8'h7F, 1'b0);
      queue_byte(8'h80, 1'b0);              // stray continuation
      queue_byte(8'hF8, 1'b0);              // invalid lead
      queue_byte(8'hFF, 1'b0);              // invalid lead
      queue_byte(8'hC2, 1'b0);              // broken: lead then ASCII
      queue_byte(8'h41, 1'b0);
      queue_char(21'h1FFFFF, 4, 0, 1'b0);   // largest four-byte value
      queue_char(u8cjk_pkg::CJK_MAIN_LO, 3, 1, 1'b1);  // end of string drops the partial
      queue_byte(8'h41, 1'b0);
      queue_char(21'h00D800, 3, 0, 1'b0);   // surrogate passes as is
      wait_drained();

      // Random text, all characters visible, both sides idling, with the
      // long receiver hold-off somewhere early on.
      tx_idle_on    = 1'b1;
      rx_idle_on    = 1'b1;
      long_hold_arm = 1'b1;
      queue_random_text(500, 1'b0);
      wait_drained();

      // CJK-only, full rate on both sides.
      write_cjk_only(1'b1);
      tx_idle_on = 1'b0;
      rx_idle_on = 1'b0;
      queue_random_text(400, 1'b1);
      wait_drained();

      // All characters, sender idling against an always-ready receiver.
      write_cjk_only(1'b0);
      tx_idle_on = 1'b1;
      queue_random_text(350, 1'b0);
      wait_drained();

      // CJK-only, full-rate sender against a stalling receiver.
      write_cjk_only(1'b1);
      tx_idle_on = 1'b0;
      rx_idle_on = 1'b1;
      queue_random_text(400, 1'b1);
      wait_drained();

      if (fail_cnt == 0 && owed_chars.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   // Watchdog: count cycles and end the run if it hangs.
   initial begin
      while (cycle_cnt < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_cnt++;
      end
      $display("timeout after %0d cycles, %0d characters still owed", cycle_cnt,
               owed_chars.size());
      $display("FAILURE");
      $finish;
   end

endmodule

@@ utf8_decoder_cjk_classifier_core.f @@
+incdir+rtl
rtl/u8cjk_pkg.sv
rtl/u8cjk_in_stage.sv
rtl/u8cjk_decode.sv
rtl/u8cjk_out_stage.sv
rtl/utf8_decoder_cjk_classifier_core.sv
tb/sv/tb_utf8_decoder_cjk_classifier_core.sv
